// ----- design/lfdtd_pkg.sv -----
// Shared constants, types and register codes for the lossy line FDTD step block.
// No dependencies; the cell, sequencer and top level files import this package.
package lfdtd_pkg;

	// Line size and derived storage geometry.
	localparam int CELLS = 1024;
	localparam int NODES = CELLS + 1;
	localparam int VA_W  = $clog2(NODES);
	localparam int IA_W  = $clog2(CELLS);

	// Fixed-point layout: signed Q2.30 values and coefficients.
	localparam int DATA_W = 32;
	localparam int FRAC   = 30;
	localparam int OPD_W  = 34;
	localparam int LO_W   = 16;
	localparam int NODE_W = 11;

	// Configuration port.
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOLT_DECAY = 3'd0,
		REG_VOLT_DRIVE = 3'd1,
		REG_CURR_DECAY = 3'd2,
		REG_CURR_DRIVE = 3'd3,
		REG_NEAR_NODE  = 3'd4,
		REG_FAR_NODE   = 3'd5
	} cfg_reg_t;

	localparam logic signed [DATA_W-1:0] DECAY_RST    = 32'sh4000_0000;
	localparam logic [NODE_W-1:0]        FAR_NODE_RST = 11'd1024;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	// Controls for one update cell: double the drive term, subtract it.
	typedef struct packed {
		logic dbl;
		logic neg;
	} cell_op_t;

	// Side data that travels through a cell beside the arithmetic.
	typedef struct packed {
		logic [VA_W-1:0]          idx;
		logic signed [DATA_W-1:0] aux;
	} tag_t;

	// Sequencer outputs toward the datapath.
	typedef struct packed {
		logic            ready;
		logic            post;
		logic            clr_we;
		logic            rd_en;
		logic [VA_W-1:0] addr;
	} ctrl_t;

endpackage

// ----- design/lfdtd_cell.sv -----
// One update cell: y = sat(ca*x +/- k*(cb*d)) with k of 1 or 2, rounded Q2.30.
// Four register stages; depends on lfdtd_pkg.
module lfdtd_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [lfdtd_pkg::DATA_W-1:0]  ca,
	input  logic signed [lfdtd_pkg::DATA_W-1:0]  x,
	input  logic signed [lfdtd_pkg::DATA_W-1:0]  cb,
	input  logic signed [lfdtd_pkg::OPD_W-1:0]   d,
	input  lfdtd_pkg::cell_op_t                  op,
	input  lfdtd_pkg::tag_t                      in_tag,
	output logic                                 out_valid,
	output logic signed [lfdtd_pkg::DATA_W-1:0]  y,
	output lfdtd_pkg::tag_t                      out_tag
);
	import lfdtd_pkg::*;

	localparam int DHI_W = OPD_W - LO_W;
	localparam int PA_W  = 2 * DATA_W;
	localparam int PH_W  = DATA_W + DHI_W;
	localparam int PL_W  = DATA_W + LO_W + 1;
	localparam int DRV_W = DATA_W + OPD_W;
	localparam int RA_W  = PA_W - FRAC;
	localparam int RD_W  = DRV_W - FRAC;
	localparam int SUM_W = RD_W + 2;

	localparam logic signed [PA_W-1:0]  RND_A   = {{(PA_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [DRV_W-1:0] RND_D   = {{(DRV_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

	logic                     valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [DATA_W-1:0] ca_s1, x_s1, cb_s1;
	logic signed [OPD_W-1:0]  d_s1;
	cell_op_t                 op_s1, op_s2, op_s3;
	tag_t                     tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [PA_W-1:0]   pa_s2;
	logic signed [PH_W-1:0]   ph_s2;
	logic signed [PL_W-1:0]   pl_s2;
	logic signed [RA_W-1:0]   ra_s3;
	logic signed [RD_W-1:0]   rd_s3;
	logic signed [DATA_W-1:0] y_s4;

	logic signed [DHI_W-1:0]  dhi;
	logic signed [PL_W-1:0]   dlo;
	logic signed [DRV_W-1:0]  ph_w, pl_w, drv;
	logic signed [PA_W-1:0]   pa_r;
	logic signed [SUM_W-1:0]  ra_w, rd_w, sum;
	logic signed [DATA_W-1:0] y_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// The wide operand is split into a signed high part and an unsigned low
	// part so that no single multiplier is much wider than 32 by 32.
	assign dhi = d_s1[OPD_W-1:LO_W];
	assign dlo = PL_W'({1'b0, d_s1[LO_W-1:0]});

	always_comb begin
		ph_w = ph_s2;
		pl_w = pl_s2;
		drv  = (ph_w <<< LO_W) + pl_w + RND_D;
		pa_r = pa_s2 + RND_A;
	end

	always_comb begin
		ra_w = ra_s3;
		rd_w = rd_s3;
		if (op_s3.dbl) begin
			rd_w = rd_w <<< 1;
		end
		sum = op_s3.neg ? (ra_w - rd_w) : (ra_w + rd_w);
		if (sum > SAT_MAX) begin
			y_d = SAT_MAX[DATA_W-1:0];
		end else if (sum < SAT_MIN) begin
			y_d = SAT_MIN[DATA_W-1:0];
		end else begin
			y_d = sum[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		ca_s1  <= ca;
		x_s1   <= x;
		cb_s1  <= cb;
		d_s1   <= d;
		op_s1  <= op;
		tag_s1 <= in_tag;

		pa_s2  <= ca_s1 * x_s1;
		ph_s2  <= cb_s1 * dhi;
		pl_s2  <= cb_s1 * dlo;
		op_s2  <= op_s1;
		tag_s2 <= tag_s1;

		ra_s3  <= pa_r[PA_W-1:FRAC];
		rd_s3  <= drv[DRV_W-1:FRAC];
		op_s3  <= op_s2;
		tag_s3 <= tag_s2;

		y_s4   <= y_d;
		tag_s4 <= tag_s3;
	end

	assign out_valid = valid_s4;
	assign y         = y_s4;
	assign out_tag   = tag_s4;

endmodule

// ----- design/lfdtd_ctrl.sv -----
// Sequencer: clearing sweep after reset, one read sweep per time step, result hand-off.
// Depends on lfdtd_pkg.
module lfdtd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              done,
	input  logic              out_free,
	output lfdtd_pkg::ctrl_t  ctrl
);
	import lfdtd_pkg::*;

	localparam logic [VA_W-1:0] LAST = VA_W'(CELLS);

	state_t          state_q, state_d;
	logic [VA_W-1:0] addr_q, addr_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		ctrl      = '0;
		ctrl.addr = addr_q;
		case (state_q)
			ST_CLEAR: begin
				ctrl.clr_we = 1'b1;
				if (addr_q == LAST) begin
					addr_d  = '0;
					state_d = ST_IDLE;
				end else begin
					addr_d = addr_q + VA_W'(1);
				end
			end
			ST_IDLE: begin
				ctrl.ready = 1'b1;
				if (start) begin
					addr_d  = '0;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				ctrl.rd_en = 1'b1;
				if (addr_q == LAST) begin
					addr_d  = '0;
					state_d = ST_DRAIN;
				end else begin
					addr_d = addr_q + VA_W'(1);
				end
			end
			ST_DRAIN: begin
				if (done) begin
					if (out_free) begin
						ctrl.post = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					ctrl.post = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ----- design/lossy_line_fdtd_step.sv -----
// Top level of the lossy transmission line FDTD step: storage, cell chain, I/O registers.
// Depends on lfdtd_pkg, lfdtd_cell and lfdtd_ctrl.
//
//   Channel  Direction  Handshake            Payload
//   cfg      in         cfg_write            cfg_index, cfg_data
//   in       in         in_valid / in_stall  source_volts
//   out      out        out_valid / out_stall step_number, near_volts, far_volts
//
// After reset the block sweeps both state memories to zero, one node per cycle, over
// all CELLS + 1 = 1025 nodes; in_stall stays high during that sweep.
// One time step is a single pass over the node memory at one node per cycle, followed
// by the read register and two four-stage update cells; the next input transaction is
// taken only after that.
// A finished result sits in the output register; the next input transaction is taken
// while it waits, and a step only stalls at its end if the previous result is still held.
module lossy_line_fdtd_step (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [lfdtd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lfdtd_pkg::DATA_W-1:0]            cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [lfdtd_pkg::DATA_W-1:0]     source_volts,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [lfdtd_pkg::DATA_W-1:0]            step_number,
	output logic signed [lfdtd_pkg::DATA_W-1:0]     near_volts,
	output logic signed [lfdtd_pkg::DATA_W-1:0]     far_volts
);
	import lfdtd_pkg::*;

	localparam logic [VA_W-1:0] LAST_NODE = VA_W'(CELLS);
	localparam logic [VA_W-1:0] LAST_CELL = VA_W'(CELLS - 1);

	// Configuration registers.
	logic signed [DATA_W-1:0] volt_decay_q, volt_drive_q, curr_decay_q, curr_drive_q;
	logic [NODE_W-1:0]        near_node_q, far_node_q;

	// Sequencer.
	ctrl_t ctrl;
	logic  start, done, out_free;

	// State memories: node voltages and cell currents (currents scaled by Z0).
	logic [DATA_W-1:0] v_mem [NODES];
	logic [DATA_W-1:0] i_mem [CELLS];
	logic              v_we, i_we, i_re;
	logic [VA_W-1:0]   v_waddr;
	logic [IA_W-1:0]   i_waddr;
	logic [DATA_W-1:0] v_wdata, i_wdata;
	logic signed [DATA_W-1:0] v_rdata_q, i_rdata_q;

	// Read stage bookkeeping.
	logic                     rd_valid_s1;
	logic [VA_W-1:0]          rd_idx_s1;
	logic signed [DATA_W-1:0] iprev_q;
	logic signed [DATA_W-1:0] vs_q;

	// Voltage cell.
	logic signed [OPD_W-1:0]  vc_d;
	cell_op_t                 vc_op;
	tag_t                     vc_in_tag, vc_tag;
	logic                     vc_valid;
	logic signed [DATA_W-1:0] vc_y;

	// Current cell.
	logic signed [DATA_W-1:0] vprev_q;
	logic signed [OPD_W-1:0]  ic_d;
	logic                     ic_in_valid;
	cell_op_t                 ic_op;
	tag_t                     ic_in_tag, ic_tag;
	logic                     ic_valid;
	logic signed [DATA_W-1:0] ic_y;

	// Observation and result.
	logic [VA_W-1:0]          near_sel, far_sel;
	logic signed [DATA_W-1:0] near_hold_q, far_hold_q;
	logic [DATA_W-1:0]        step_q;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        step_number_q;
	logic signed [DATA_W-1:0] near_volts_q, far_volts_q;

	// Register writes. Unknown indexes fall to the default arm and change nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_decay_q <= DECAY_RST;
			volt_drive_q <= '0;
			curr_decay_q <= DECAY_RST;
			curr_drive_q <= '0;
			near_node_q  <= '0;
			far_node_q   <= FAR_NODE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_VOLT_DECAY: volt_decay_q <= cfg_data;
				REG_VOLT_DRIVE: volt_drive_q <= cfg_data;
				REG_CURR_DECAY: curr_decay_q <= cfg_data;
				REG_CURR_DRIVE: curr_drive_q <= cfg_data;
				REG_NEAR_NODE:  near_node_q  <= cfg_data[NODE_W-1:0];
				REG_FAR_NODE:   far_node_q   <= cfg_data[NODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Observation indexes beyond the line are pinned to the load node.
	always_comb begin
		near_sel = (32'(near_node_q) > 32'(CELLS)) ? LAST_NODE : VA_W'(near_node_q);
		far_sel  = (32'(far_node_q) > 32'(CELLS)) ? LAST_NODE : VA_W'(far_node_q);
	end

	assign start    = in_valid & ctrl.ready;
	assign in_stall = ~ctrl.ready;
	assign out_free = ~out_valid_q | ~out_stall;
	// The step is complete once the current of the last cell has been computed.
	assign done     = ic_valid && (ic_tag.idx == LAST_CELL);

	lfdtd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.done     (done),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// Memory ports. The clearing sweep owns the write ports right after reset; during a
	// step the voltage cell writes node voltages and the current cell writes currents.
	// Writes always trail the read sweep, so a read never sees a value of this step.
	always_comb begin
		v_we    = ctrl.clr_we | vc_valid;
		v_waddr = ctrl.clr_we ? ctrl.addr : vc_tag.idx;
		v_wdata = ctrl.clr_we ? '0 : vc_y;
		if (ctrl.clr_we) begin
			i_we    = (ctrl.addr != LAST_NODE);
			i_waddr = ctrl.addr[IA_W-1:0];
			i_wdata = '0;
		end else begin
			i_we    = ic_valid;
			i_waddr = ic_tag.idx[IA_W-1:0];
			i_wdata = ic_y;
		end
		i_re = ctrl.rd_en && (ctrl.addr != LAST_NODE);
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			v_mem[v_waddr] <= v_wdata;
		end
		if (ctrl.rd_en) begin
			v_rdata_q <= v_mem[ctrl.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (i_we) begin
			i_mem[i_waddr] <= i_wdata;
		end
		if (i_re) begin
			i_rdata_q <= i_mem[ctrl.addr[IA_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= ctrl.rd_en;
		end
	end

	// The previous cell current is kept one node behind the read sweep so that each
	// node sees both of its neighboring currents.
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_idx_s1 <= ctrl.addr;
		end
		if (rd_valid_s1) begin
			iprev_q <= i_rdata_q;
		end
		if (start) begin
			vs_q <= source_volts;
		end
	end

	// Drive operand for the node update. The source node sees the matched source, the
	// load node the matched load; both double the rounded drive term.
	always_comb begin
		logic signed [OPD_W-1:0] v_ext, i_ext, ip_ext, vs_ext;
		v_ext  = v_rdata_q;
		i_ext  = i_rdata_q;
		ip_ext = iprev_q;
		vs_ext = vs_q;
		if (rd_idx_s1 == '0) begin
			vc_d   = vs_ext - v_ext - i_ext;
			vc_op  = '{dbl: 1'b1, neg: 1'b0};
		end else if (rd_idx_s1 == LAST_NODE) begin
			vc_d   = ip_ext - v_ext;
			vc_op  = '{dbl: 1'b1, neg: 1'b0};
		end else begin
			vc_d   = i_ext - ip_ext;
			vc_op  = '{dbl: 1'b0, neg: 1'b1};
		end
		vc_in_tag.idx = rd_idx_s1;
		vc_in_tag.aux = iprev_q;
	end

	lfdtd_cell u_volt_cell (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_valid_s1),
		.ca        (volt_decay_q),
		.x         (v_rdata_q),
		.cb        (volt_drive_q),
		.d         (vc_d),
		.op        (vc_op),
		.in_tag    (vc_in_tag),
		.out_valid (vc_valid),
		.y         (vc_y),
		.out_tag   (vc_tag)
	);

	// The new voltage of node i completes cell i-1: its old current rode along in the
	// tag, and the new voltage of node i-1 is held from the cycle before.
	always_ff @(posedge clk) begin
		if (vc_valid) begin
			vprev_q <= vc_y;
			if (vc_tag.idx == near_sel) begin
				near_hold_q <= vc_y;
			end
			if (vc_tag.idx == far_sel) begin
				far_hold_q <= vc_y;
			end
		end
	end

	always_comb begin
		logic signed [OPD_W-1:0] vy_ext, vp_ext;
		vy_ext        = vc_y;
		vp_ext        = vprev_q;
		ic_d          = vy_ext - vp_ext;
		ic_in_valid   = vc_valid && (vc_tag.idx != '0);
		ic_op         = '{dbl: 1'b0, neg: 1'b1};
		ic_in_tag.idx = vc_tag.idx - VA_W'(1);
		ic_in_tag.aux = '0;
	end

	lfdtd_cell u_curr_cell (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ic_in_valid),
		.ca        (curr_decay_q),
		.x         (vc_tag.aux),
		.cb        (curr_drive_q),
		.d         (ic_d),
		.op        (ic_op),
		.in_tag    (ic_in_tag),
		.out_valid (ic_valid),
		.y         (ic_y),
		.out_tag   (ic_tag)
	);

	// Output register and step counter. A new result may replace one that is taken in
	// the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (ctrl.post) begin
			out_valid_q <= 1'b1;
			step_q      <= step_q + DATA_W'(1);
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.post) begin
			step_number_q <= step_q;
			near_volts_q  <= near_hold_q;
			far_volts_q   <= far_hold_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign step_number = step_number_q;
	assign near_volts  = near_volts_q;
	assign far_volts   = far_volts_q;

endmodule

// ----- design/lfdtd_checker.sv -----
// Port-level checks for lossy_line_fdtd_step, attached by the bind at the end.
// Depends only on the top level's port names.
module lfdtd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] step_number,
	input logic [31:0] near_volts,
	input logic [31:0] far_volts
);

	logic [1:0]  pend_q;
	logic [31:0] exp_step_q;
	logic        in_acc, out_acc;

	assign in_acc  = in_valid & ~in_stall;
	assign out_acc = out_valid & ~out_stall;

	// Transactions taken but not yet answered, and the step index expected next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			exp_step_q <= '0;
		end else begin
			if (in_acc && !out_acc) begin
				pend_q <= pend_q + 2'd1;
			end else if (out_acc && !in_acc) begin
				pend_q <= pend_q - 2'd1;
			end
			if (out_acc) begin
				exp_step_q <= exp_step_q + 32'd1;
			end
		end
	end

	// One step at a time: a taken input closes the input side on the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input taken while a step was still running");

	// Every result answers an input that was taken.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 2'd0))
		else $error("result shown without a pending input");

	// Results carry consecutive step indexes.
	a_step_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (step_number == exp_step_q))
		else $error("step number out of sequence");

	// A held result does not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(step_number)
			&& $stable(near_volts) && $stable(far_volts)))
		else $error("stalled result changed or dropped");

endmodule

bind lossy_line_fdtd_step lfdtd_checker u_lfdtd_checker (.*);
